@@ hw/rtl/cmpd_pkg.sv @@
// Package for the crop / max-pool downscaler: sizes, config indexes,
// the locate-to-pool control struct and the block result function.
// No dependencies.
package cmpd_pkg;

    localparam int CROP_SIZE     = 112;
    localparam int POOL_SIZE     = 4;     // must be a power of two
    localparam int MAX_FRAME_DIM = 2048;
    localparam int PASS_DIM      = 28;

    localparam int OUT_DIM     = CROP_SIZE / POOL_SIZE;
    localparam int POOLED_SPAN = OUT_DIM * POOL_SIZE;
    localparam int PASS_TOTAL  = PASS_DIM * PASS_DIM;
    localparam int CROP_TOTAL  = OUT_DIM * OUT_DIM;
    localparam int MAX_TOTAL   = (PASS_TOTAL > CROP_TOTAL) ? PASS_TOTAL : CROP_TOTAL;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int COL_W     = $clog2(MAX_FRAME_DIM);
    localparam int POOL_BITS = $clog2(POOL_SIZE);
    localparam int BX_W      = $clog2(OUT_DIM);
    localparam int OCNT_W    = $clog2(MAX_TOTAL + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd160;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd120;

    typedef struct packed {
        logic            pass;     // 28x28 pass-through frame
        logic            update;   // pixel lies in the pooled crop
        logic            first;    // first pixel of its block
        logic            emit;     // a result goes out for this pixel
        logic            last;     // final result of the frame
        logic [BX_W-1:0] bx;       // output column of the block
    } t_loc;

    // 128 - m wrapped to 8 bits, positive values forced to 127
    function automatic logic [PIX_W-1:0] block_result(input logic [PIX_W-1:0] m);
        logic [PIX_W-1:0] r;
        r = 8'd128 - m;
        if (!r[PIX_W-1] && (r != '0)) begin
            r = 8'd127;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/cmpd_stream_if.sv @@
// Stream interfaces for the downscaler: pixel input and result output.
// Depends on cmpd_pkg.
interface cmpd_pix_if;
    logic                        valid;
    logic                        ready;
    logic [cmpd_pkg::PIX_W-1:0]  pixel;
    logic                        frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface cmpd_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [cmpd_pkg::PIX_W-1:0]  value;
    logic                               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

@@ hw/rtl/crop_maxpool_downscale_core.sv @@
// Top level of the crop / max-pool downscaler: input register, config
// registers, result register. Depends on cmpd_pkg, cmpd_stream_if, cmpd_locate, cmpd_pool.
//
//  channel   dir  handshake      payload
//  i_pix     in   valid/ready    pixel[7:0], frame_start
//  o_res     out  valid/ready    value[7:0] signed, last
//  i_cfg_*   in   write enable   i_cfg_idx[0], i_cfg_data[11:0]
//
// One pixel per cycle sustained while the result side is not stalled; a pixel is
// held in the input register, then decoded, pooled and its result registered.
// Throughput is set by the single compare/update of the partial-max row.
// Synchronous active-low reset clears counters, maxima and valid flags;
// config returns to 160x120. A stalled result holds the input register.
module crop_maxpool_downscale_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cmpd_pix_if.sink                         i_pix,
    cmpd_res_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [cmpd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cmpd_pkg::CFG_W-1:0]       i_cfg_data
);

    logic                              r_in_valid;
    logic [cmpd_pkg::PIX_W-1:0]        r_in_pixel;
    logic                              r_in_start;
    logic                              r_out_valid;
    logic signed [cmpd_pkg::PIX_W-1:0] r_out_value;
    logic                              r_out_last;
    logic [cmpd_pkg::CFG_W-1:0]        r_frame_width;
    logic [cmpd_pkg::CFG_W-1:0]        r_frame_height;

    logic                              w_step;
    cmpd_pkg::t_loc                    w_loc;
    logic signed [cmpd_pkg::PIX_W-1:0] w_value;

    assign w_step      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_in_valid || w_step;
    assign o_res.valid = r_out_valid;
    assign o_res.value = r_out_value;
    assign o_res.last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= cmpd_pkg::RST_FRAME_WIDTH;
            r_frame_height <= cmpd_pkg::RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cmpd_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                cmpd_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_valid <= i_pix.valid;
        end
        if (i_pix.ready && i_pix.valid) begin
            r_in_pixel <= i_pix.pixel;
            r_in_start <= i_pix.frame_start;
        end
    end

    cmpd_locate u_locate (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_start        (r_in_start),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_loc          (w_loc)
    );

    cmpd_pool u_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_pixel (r_in_pixel),
        .i_loc   (w_loc),
        .o_value (w_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_loc.emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_step && w_loc.emit) begin
            r_out_value <= w_value;
            r_out_last  <= w_loc.last;
        end
    end

    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_step))
        else $error("result appeared without a processed pixel");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_step) |=> (r_in_valid && $stable(r_in_pixel)
                                     && $stable(r_in_start)))
        else $error("pending pixel lost while output stalled");

endmodule

@@ hw/rtl/cmpd_locate.sv @@
// Row/column/output counters and crop window decode for the downscaler.
// Depends on cmpd_pkg.
module cmpd_locate (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_start,
    input  logic [cmpd_pkg::CFG_W-1:0]    i_frame_width,
    input  logic [cmpd_pkg::CFG_W-1:0]    i_frame_height,
    output cmpd_pkg::t_loc                o_loc
);

    logic [cmpd_pkg::COL_W-1:0]  r_col, n_col;
    logic [cmpd_pkg::COL_W-1:0]  r_row, n_row;
    logic [cmpd_pkg::OCNT_W-1:0] r_out_cnt, n_out_cnt;

    logic [cmpd_pkg::COL_W-1:0]  w_col, w_row;
    logic [cmpd_pkg::OCNT_W-1:0] w_out;
    logic [cmpd_pkg::CFG_W-1:0]  w_dx, w_dy;
    logic [cmpd_pkg::COL_W-1:0]  w_sx, w_sy, w_cx, w_cy;
    logic [cmpd_pkg::COL_W:0]    w_col_inc;
    logic                        w_fit, w_in_crop, w_wrap;

    always_comb begin
        w_col = i_start ? '0 : r_col;
        w_row = i_start ? '0 : r_row;
        w_out = i_start ? '0 : r_out_cnt;

        w_fit = (32'(i_frame_width) >= cmpd_pkg::CROP_SIZE)
             && (32'(i_frame_height) >= cmpd_pkg::CROP_SIZE)
             && (32'(i_frame_width) <= cmpd_pkg::MAX_FRAME_DIM)
             && (32'(i_frame_height) <= cmpd_pkg::MAX_FRAME_DIM);

        // crop origin is half the surplus, rounded down
        w_dx = i_frame_width - cmpd_pkg::CFG_W'(cmpd_pkg::CROP_SIZE);
        w_dy = i_frame_height - cmpd_pkg::CFG_W'(cmpd_pkg::CROP_SIZE);
        w_sx = cmpd_pkg::COL_W'(w_dx >> 1);
        w_sy = cmpd_pkg::COL_W'(w_dy >> 1);
        w_cx = w_col - w_sx;
        w_cy = w_row - w_sy;

        w_in_crop = w_fit && (w_col >= w_sx) && (w_row >= w_sy)
                 && (32'(w_cx) < cmpd_pkg::POOLED_SPAN)
                 && (32'(w_cy) < cmpd_pkg::POOLED_SPAN)
                 && (32'(w_out) < cmpd_pkg::CROP_TOTAL);

        o_loc.pass   = (32'(i_frame_width) == cmpd_pkg::PASS_DIM)
                    && (32'(i_frame_height) == cmpd_pkg::PASS_DIM);
        o_loc.update = !o_loc.pass && w_in_crop;
        o_loc.first  = (w_cx[cmpd_pkg::POOL_BITS-1:0] == '0)
                    && (w_cy[cmpd_pkg::POOL_BITS-1:0] == '0);
        o_loc.bx     = cmpd_pkg::BX_W'(w_cx >> cmpd_pkg::POOL_BITS);
        if (o_loc.pass) begin
            o_loc.emit = 32'(w_out) < cmpd_pkg::PASS_TOTAL;
            o_loc.last = 32'(w_out) == cmpd_pkg::PASS_TOTAL - 1;
        end else begin
            o_loc.emit = o_loc.update && (&w_cx[cmpd_pkg::POOL_BITS-1:0])
                      && (&w_cy[cmpd_pkg::POOL_BITS-1:0]);
            o_loc.last = 32'(w_out) == cmpd_pkg::CROP_TOTAL - 1;
        end

        // column wraps at the frame width or at the counter limit
        w_col_inc = {1'b0, w_col} + 1'b1;
        w_wrap = (32'(w_col_inc) >= 32'(i_frame_width))
              || (w_col == cmpd_pkg::COL_W'(cmpd_pkg::MAX_FRAME_DIM - 1));
        if (w_wrap) begin
            n_col = '0;
            n_row = (w_row == cmpd_pkg::COL_W'(cmpd_pkg::MAX_FRAME_DIM - 1))
                  ? w_row : w_row + 1'b1;
        end else begin
            n_col = w_col_inc[cmpd_pkg::COL_W-1:0];
            n_row = w_row;
        end
        n_out_cnt = w_out + cmpd_pkg::OCNT_W'(o_loc.emit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_out_cnt <= '0;
        end else if (i_step) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_out_cnt <= n_out_cnt;
        end
    end

    a_out_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_out_cnt) <= cmpd_pkg::MAX_TOTAL)
        else $error("output count past frame total");

    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_loc.emit |-> (o_loc.pass || o_loc.update))
        else $error("result outside pass-through and crop");

endmodule

@@ hw/rtl/cmpd_pool.sv @@
// Row of partial block maxima and the per-pixel result value.
// Depends on cmpd_pkg.
module cmpd_pool (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [cmpd_pkg::PIX_W-1:0]        i_pixel,
    input  cmpd_pkg::t_loc                    i_loc,
    output logic signed [cmpd_pkg::PIX_W-1:0] o_value
);

    logic [cmpd_pkg::PIX_W-1:0] r_pmax [cmpd_pkg::OUT_DIM];
    logic [cmpd_pkg::PIX_W-1:0] w_cur, n_max;

    always_comb begin
        w_cur = (32'(i_loc.bx) < cmpd_pkg::OUT_DIM) ? r_pmax[i_loc.bx] : '0;
        if (i_loc.first || (i_pixel > w_cur)) begin
            n_max = i_pixel;
        end else begin
            n_max = w_cur;
        end
        o_value = i_loc.pass ? $signed(i_pixel) : $signed(cmpd_pkg::block_result(n_max));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cmpd_pkg::OUT_DIM; k++) begin
                r_pmax[k] <= '0;
            end
        end else if (i_step && i_loc.update) begin
            r_pmax[i_loc.bx] <= n_max;
        end
    end

endmodule
